FILE: rtl/lwpm_pkg.sv
// ----------------------------------------------------------------------------
// lwpm_pkg: shared types and helpers of the lattice walk pivot move unit
// Coordinate widths, item and result records, the control record that
// steers the cell chain, and the per-point symmetry mapping.
// ----------------------------------------------------------------------------
package lwpm_pkg;

  // default walk length
  localparam int unsigned NUM_STEPS_DEF = 256;

  // field widths
  localparam int unsigned CoordW = 10;
  localparam int unsigned PosW   = 8;
  localparam int unsigned RotW   = 2;
  localparam int unsigned WrW    = 9;

  // item kinds
  typedef enum logic [1:0] {
    ACT_PIVOT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // one input item, unpacked
  typedef struct packed {
    action_e             action;
    logic [PosW-1:0]     pos;
    logic [RotW-1:0]     rot_xx;
    logic [RotW-1:0]     rot_xy;
    logic [RotW-1:0]     rot_yx;
    logic [RotW-1:0]     rot_yy;
    logic [WrW-1:0]      write_x;
    logic [WrW-1:0]      write_y;
  } item_t;

  // one result item
  typedef struct packed {
    logic              accepted;
    logic [CoordW-1:0] read_x;
    logic [CoordW-1:0] read_y;
  } result_t;

  // probe travelling down the chain
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              tail;
    logic              hit;
  } probe_t;

  // control record broadcast to every cell
  typedef struct packed {
    logic              load_raw;
    logic              load_map;
    logic              shift;
    logic              commit;
    logic              wr_en;
    logic [PosW-1:0]   piv;
    logic [CoordW-1:0] piv_x;
    logic [CoordW-1:0] piv_y;
    logic [RotW-1:0]   m_xx;
    logic [RotW-1:0]   m_xy;
    logic [RotW-1:0]   m_yx;
    logic [RotW-1:0]   m_yy;
    logic [CoordW-1:0] wr_x;
    logic [CoordW-1:0] wr_y;
  } cell_ctrl_t;

  // product of a matrix entry in -2..1 with a wrapped coordinate difference
  function automatic logic [CoordW-1:0] scale_coord(logic [RotW-1:0] m,
                                                    logic [CoordW-1:0] d);
    logic [CoordW-1:0] res;
    case (m)
      2'b00:   res = '0;
      2'b01:   res = d;
      2'b11:   res = CoordW'(0) - d;
      2'b10:   res = CoordW'(0) - {d[CoordW-2:0], 1'b0};
      default: res = '0;
    endcase
    return res;
  endfunction

  // one output coordinate of p + R(q - p)
  function automatic logic [CoordW-1:0] map_coord(logic [CoordW-1:0] p,
                                                  logic [RotW-1:0] ma,
                                                  logic [RotW-1:0] mb,
                                                  logic [CoordW-1:0] da,
                                                  logic [CoordW-1:0] db);
    return p + scale_coord(ma, da) + scale_coord(mb, db);
  endfunction

endpackage

FILE: rtl/lwpm_cell.sv
// ----------------------------------------------------------------------------
// lwpm_cell: one walk point of the cell chain
// Holds its point and one probe slot. Probes move one cell down per cycle
// while shifting; a head cell flags a tail probe that lands on its point.
// ----------------------------------------------------------------------------
module lwpm_cell
  import lwpm_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  probe_t     probe_i,
  output probe_t     probe_o
);

  logic [CoordW-1:0] pt_x_q, pt_y_q;
  probe_t            probe_q;
  logic              head;
  logic              match;
  logic              wr_hit;
  logic [CoordW-1:0] dx, dy;
  logic [CoordW-1:0] map_x, map_y;

  // head cells sit at or below the pivot index
  assign head   = (Idx <= 32'(ctrl_i.piv));
  assign wr_hit = ctrl_i.wr_en && (Idx == 32'(ctrl_i.piv));

  // collision of a passing tail probe with this head point
  assign match = head && probe_q.tail &&
                 (probe_q.x == pt_x_q) && (probe_q.y == pt_y_q);

  always_comb begin
    probe_o     = probe_q;
    probe_o.hit = probe_q.hit | match;
  end

  // map own point about the pivot point
  assign dx    = pt_x_q - ctrl_i.piv_x;
  assign dy    = pt_y_q - ctrl_i.piv_y;
  assign map_x = map_coord(ctrl_i.piv_x, ctrl_i.m_xx, ctrl_i.m_xy, dx, dy);
  assign map_y = map_coord(ctrl_i.piv_y, ctrl_i.m_yx, ctrl_i.m_yy, dx, dy);

  // stored point: straight line after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_x_q <= CoordW'(Idx);
      pt_y_q <= '0;
    end else if (wr_hit) begin
      pt_x_q <= ctrl_i.wr_x;
      pt_y_q <= ctrl_i.wr_y;
    end else if (ctrl_i.commit && probe_q.tail) begin
      pt_x_q <= probe_q.x;
      pt_y_q <= probe_q.y;
    end
  end

  // probe slot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_raw) begin
      probe_q <= '{x: pt_x_q, y: pt_y_q, tail: 1'b0, hit: 1'b0};
    end else if (ctrl_i.load_map) begin
      probe_q <= '{x: map_x, y: map_y, tail: !head, hit: 1'b0};
    end else if (ctrl_i.shift) begin
      probe_q <= probe_i;
    end
  end

endmodule

FILE: rtl/lwpm_ctrl.sv
// ----------------------------------------------------------------------------
// lwpm_ctrl: sequencer of the lattice walk pivot move unit
// Takes one item at a time, steers the cell chain through fetch, map, check
// and commit or through a write, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lwpm_ctrl
  import lwpm_pkg::*;
#(
  parameter int unsigned NumSteps = NUM_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  item_t      item_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output result_t    result_o,
  input  probe_t     cell0_i,
  output cell_ctrl_t ctrl_o
);

  localparam int unsigned CntW = $clog2(NumSteps + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_MAP,
    S_CHECK,
    S_COMMIT,
    S_WRITE,
    S_DONE
  } state_e;

  state_e            state_q;
  action_e           act_q;
  logic [PosW-1:0]   pos_q;
  logic [RotW-1:0]   m_xx_q, m_xy_q, m_yx_q, m_yy_q;
  logic [CoordW-1:0] wr_x_q, wr_y_q;
  logic [CoordW-1:0] px_q, py_q;
  logic [CntW-1:0]   cnt_q;
  logic              reject_q;
  result_t           res_q;
  logic              m_valid_q;
  result_t           m_res_q;
  logic              pos_ok;
  logic              at_pos;
  logic              cnt_last;

  assign pos_ok   = (32'(item_i.pos) < NumSteps);
  assign at_pos   = (32'(cnt_q) == 32'(pos_q));
  assign cnt_last = (cnt_q == CntW'(NumSteps - 1));

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= ACT_PIVOT;
      pos_q     <= '0;
      m_xx_q    <= '0;
      m_xy_q    <= '0;
      m_yx_q    <= '0;
      m_yy_q    <= '0;
      wr_x_q    <= '0;
      wr_y_q    <= '0;
      px_q      <= '0;
      py_q      <= '0;
      cnt_q     <= '0;
      reject_q  <= 1'b0;
      res_q     <= '0;
      m_valid_q <= 1'b0;
      m_res_q   <= '0;
    end else begin
      // output register: load a finished result or retire a taken one
      if ((state_q == S_DONE) && (!m_valid_q || m_ready_i)) begin
        m_valid_q <= 1'b1;
        m_res_q   <= res_q;
      end else if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            act_q  <= item_i.action;
            pos_q  <= item_i.pos;
            m_xx_q <= item_i.rot_xx;
            m_xy_q <= item_i.rot_xy;
            m_yx_q <= item_i.rot_yx;
            m_yy_q <= item_i.rot_yy;
            wr_x_q <= {item_i.write_x[WrW-1], item_i.write_x};
            wr_y_q <= {item_i.write_y[WrW-1], item_i.write_y};
            cnt_q  <= '0;
            case (item_i.action)
              ACT_PIVOT: begin
                res_q   <= '0;
                state_q <= pos_ok ? S_LOAD : S_DONE;
              end
              ACT_READ: begin
                res_q   <= '{accepted: 1'b1, read_x: '0, read_y: '0};
                state_q <= pos_ok ? S_LOAD : S_DONE;
              end
              ACT_WRITE: begin
                res_q   <= '{accepted: 1'b1, read_x: '0, read_y: '0};
                state_q <= S_WRITE;
              end
              default: begin
                res_q   <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          state_q <= S_FETCH;
        end
        // rotate raw points until the requested one reaches cell 0
        S_FETCH: begin
          if (at_pos) begin
            if (act_q == ACT_READ) begin
              res_q   <= '{accepted: 1'b1, read_x: cell0_i.x, read_y: cell0_i.y};
              state_q <= S_DONE;
            end else begin
              px_q    <= cell0_i.x;
              py_q    <= cell0_i.y;
              state_q <= S_MAP;
            end
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_MAP: begin
          cnt_q    <= '0;
          reject_q <= 1'b0;
          state_q  <= S_CHECK;
        end
        // one full turn of the mapped probes
        S_CHECK: begin
          if (cell0_i.tail && cell0_i.hit) begin
            reject_q <= 1'b1;
          end
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_last) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          res_q.accepted <= !reject_q;
          state_q        <= S_DONE;
        end
        S_WRITE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!m_valid_q || m_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;
  assign result_o  = m_res_q;

  // chain control
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.load_raw = (state_q == S_LOAD);
    ctrl_o.load_map = (state_q == S_MAP);
    ctrl_o.shift    = ((state_q == S_FETCH) && !at_pos) || (state_q == S_CHECK);
    ctrl_o.commit   = (state_q == S_COMMIT) && !reject_q;
    ctrl_o.wr_en    = (state_q == S_WRITE);
    ctrl_o.piv      = pos_q;
    ctrl_o.piv_x    = px_q;
    ctrl_o.piv_y    = py_q;
    ctrl_o.m_xx     = m_xx_q;
    ctrl_o.m_xy     = m_xy_q;
    ctrl_o.m_yx     = m_yx_q;
    ctrl_o.m_yy     = m_yy_q;
    ctrl_o.wr_x     = wr_x_q;
    ctrl_o.wr_y     = wr_y_q;
  end

endmodule

FILE: rtl/lattice_walk_pivot_move_unit.sv
// ----------------------------------------------------------------------------
// lattice_walk_pivot_move_unit: pivot moves on a 2-D lattice walk
// A chain of point cells holds the walk; probes rotate down the chain to
// fetch points and to check mapped tail points against the head.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_axis    in   position, rot_xx/xy/yx/yy, write_x/y    action
//  m_axis    out  read_x, read_y                          accepted
//
//  a pivot at index p rotates the raw points to index p, then makes one
//  full turn of the probe chain; a read at index p only rotates to p;
//  a write, an unused kind and an out-of-range pivot or read use neither.
//  one item at a time; a finished result waits in the output register while
//  the next item is taken. reset restores the straight line (i, 0) at once.
// ----------------------------------------------------------------------------
module lattice_walk_pivot_move_unit
  import lwpm_pkg::*;
#(
  parameter int unsigned NumSteps = NUM_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position, rot_xx, rot_xy, rot_yx, rot_yy, write_x, write_y, zero pad
  input  logic [39:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_x, read_y, zero pad
  output logic [23:0] m_axis_tdata,
  // accepted
  output logic [0:0]  m_axis_tuser
);

  item_t      item;
  result_t    result;
  cell_ctrl_t cell_ctrl;
  probe_t     probe_w [NumSteps];

  // unpack the input transfer
  always_comb begin
    item.action  = action_e'(s_axis_tuser);
    item.pos     = s_axis_tdata[7:0];
    item.rot_xx  = s_axis_tdata[9:8];
    item.rot_xy  = s_axis_tdata[11:10];
    item.rot_yx  = s_axis_tdata[13:12];
    item.rot_yy  = s_axis_tdata[15:14];
    item.write_x = s_axis_tdata[24:16];
    item.write_y = s_axis_tdata[33:25];
  end

  lwpm_ctrl #(
    .NumSteps (NumSteps)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .item_i    (item),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (result),
    .cell0_i   (probe_w[0]),
    .ctrl_o    (cell_ctrl)
  );

  // chain of cells, each fed by its upper neighbor, the top one by cell 0
  for (genvar c = 0; c < NumSteps; c++) begin : g_cell
    lwpm_cell #(
      .Idx (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .probe_i (probe_w[(c + 1) % NumSteps]),
      .probe_o (probe_w[c])
    );
  end

  // pack the output transfer
  assign m_axis_tdata = {4'b0000, result.read_y, result.read_x};
  assign m_axis_tuser = result.accepted;

endmodule

FILE: rtl/lwpm_checker.sv
// ----------------------------------------------------------------------------
// lwpm_checker: port-level checks of the lattice walk pivot move unit
// Watches the stream ports for ordering and result-format slips.
// ----------------------------------------------------------------------------
module lwpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an accepted input transfer makes the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a rejected or empty result carries no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
    else $error("coordinates on a result without acceptance");

  // a new result only shows up at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a pending item");

endmodule

bind lattice_walk_pivot_move_unit lwpm_checker u_lwpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/tb_lattice_walk_pivot_move_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_walk_pivot_move_unit: self-checking bench of the pivot move unit
// Keeps its own copy of the walk, predicts the result of every item taken on
// the input stream and compares each output transfer field by field. A short
// directed part covers the reset walk, empty tails, collapsing and overflowing
// matrices, extreme writes and the unused kind. Random pivots, reads and
// writes follow, under random idling on both streams and one long output
// hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_lattice_walk_pivot_move_unit;
  import lwpm_pkg::*;

  localparam int unsigned WalkLen       = NUM_STEPS_DEF;
  localparam int unsigned RandomItems   = 500;
  localparam int unsigned QuietItems    = 100;
  localparam int unsigned HoldOffCycles = 3000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned CycleLimit    = 2_000_000;

  // matrix entries as 2-bit codes
  localparam logic [1:0] MZ = 2'b00;
  localparam logic [1:0] MP = 2'b01;
  localparam logic [1:0] MN = 2'b11;
  localparam logic [1:0] M2 = 2'b10;

  // ---------------------------------------------------------------------------
  // walk tracker: predicted walk and the queue of expected results
  // ---------------------------------------------------------------------------
  class walk_tracker;
    logic [CoordW-1:0] walk_x [WalkLen];
    logic [CoordW-1:0] walk_y [WalkLen];
    result_t           pending[$];
    int unsigned       errors;
    int unsigned       n_applied, n_rejected, n_reads, n_writes;

    function new();
      for (int i = 0; i < WalkLen; i++) begin
        walk_x[i] = CoordW'(i);
        walk_y[i] = '0;
      end
      errors = 0;
      n_applied = 0;
      n_rejected = 0;
      n_reads = 0;
      n_writes = 0;
    endfunction

    // p + a*da + b*db, wrapped to the coordinate width
    function logic [CoordW-1:0] turn_coord(logic [CoordW-1:0] p, logic [1:0] a,
                                           logic [1:0] b, logic [CoordW-1:0] da,
                                           logic [CoordW-1:0] db);
      int sa, sb, v;
      sa = $signed(a);
      sb = $signed(b);
      v  = int'(p) + sa * int'(da) + sb * int'(db);
      return v[CoordW-1:0];
    endfunction

    // note a transfer taken by the unit and queue its expected result
    function void note_item(item_t it);
      result_t           r;
      logic [CoordW-1:0] px, py, dx, dy;
      logic [CoordW-1:0] mx [WalkLen];
      logic [CoordW-1:0] my [WalkLen];
      bit                clash;
      int                piv;
      r   = '0;
      piv = int'(it.pos);
      case (it.action)
        ACT_PIVOT: begin
          clash = 1'b0;
          px = walk_x[piv];
          py = walk_y[piv];
          // map the tail and look for a landing on a head point
          for (int k = piv + 1; k < WalkLen; k++) begin
            if (clash) break;
            dx = walk_x[k] - px;
            dy = walk_y[k] - py;
            mx[k] = turn_coord(px, it.rot_xx, it.rot_xy, dx, dy);
            my[k] = turn_coord(py, it.rot_yx, it.rot_yy, dx, dy);
            for (int j = 0; j <= piv; j++) begin
              if (walk_x[j] == mx[k] && walk_y[j] == my[k]) clash = 1'b1;
            end
          end
          if (!clash) begin
            for (int k = piv + 1; k < WalkLen; k++) begin
              walk_x[k] = mx[k];
              walk_y[k] = my[k];
            end
            n_applied++;
          end else begin
            n_rejected++;
          end
          r.accepted = !clash;
        end
        ACT_READ: begin
          r.accepted = 1'b1;
          r.read_x   = walk_x[piv];
          r.read_y   = walk_y[piv];
          n_reads++;
        end
        ACT_WRITE: begin
          r.accepted  = 1'b1;
          walk_x[piv] = {it.write_x[WrW-1], it.write_x};
          walk_y[piv] = {it.write_y[WrW-1], it.write_y};
          n_writes++;
        end
        default: begin
        end
      endcase
      pending.push_back(r);
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_result(logic acc, logic [CoordW-1:0] rx, logic [CoordW-1:0] ry);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result accepted=%0b x=%0d y=%0d", $time, acc,
                 $signed(rx), $signed(ry));
        errors++;
        return;
      end
      e = pending.pop_front();
      if (acc !== e.accepted) begin
        $display("%0t: accepted mismatch, expected %0b, got %0b", $time, e.accepted, acc);
        errors++;
      end
      if (rx !== e.read_x) begin
        $display("%0t: read_x mismatch, expected %0d, got %0d", $time,
                 $signed(e.read_x), $signed(rx));
        errors++;
      end
      if (ry !== e.read_y) begin
        $display("%0t: read_y mismatch, expected %0d, got %0d", $time,
                 $signed(e.read_y), $signed(ry));
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and unit
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  bit          quiet_phase   = 1'b0;
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;
  int unsigned cycle_count   = 0;

  walk_tracker tracker = new();

  always #10 clk_i = ~clk_i;

  lattice_walk_pivot_move_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // run length guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, tracker.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tuser[0], m_axis_tdata[9:0], m_axis_tdata[19:10]);
    end
  end

  // output ready: random stall bursts, one long hold-off on request
  initial begin : out_ready_gen
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req  = 1'b0;
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic item_t make_item(action_e a, logic [7:0] pos,
                                      logic [1:0] xx, logic [1:0] xy,
                                      logic [1:0] yx, logic [1:0] yy,
                                      logic [8:0] wx, logic [8:0] wy);
    item_t it;
    it.action  = a;
    it.pos     = pos;
    it.rot_xx  = xx;
    it.rot_xy  = xy;
    it.rot_yx  = yx;
    it.rot_yy  = yy;
    it.write_x = wx;
    it.write_y = wy;
    return it;
  endfunction

  // offer one item, wait for the transfer, then maybe idle a burst
  task automatic send_item(input item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.write_y, it.write_x, it.rot_yy, it.rot_yx,
                      it.rot_xy, it.rot_xx, it.pos};
    s_axis_tuser  <= it.action;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(it);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // random coordinate within the write range
  function automatic logic [8:0] rand_coord();
    int v;
    v = int'($urandom_range(0, 510)) - 255;
    return v[8:0];
  endfunction

  initial begin : main
    logic [1:0] sym [8][4];
    item_t      it;
    int         sel, pick;

    // the eight lattice symmetries, row-major
    sym[0] = '{MP, MZ, MZ, MP};
    sym[1] = '{MZ, MN, MP, MZ};
    sym[2] = '{MN, MZ, MZ, MN};
    sym[3] = '{MZ, MP, MN, MZ};
    sym[4] = '{MP, MZ, MZ, MN};
    sym[5] = '{MN, MZ, MZ, MP};
    sym[6] = '{MZ, MP, MP, MZ};
    sym[7] = '{MZ, MN, MN, MZ};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset walk, empty tail, collapse, overflow, shear, extremes
    send_item(make_item(ACT_READ,  8'd0,   MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd255, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd255, MZ, MN, MP, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd255, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd0,   MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd128, MZ, MN, MP, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd200, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd10,  M2, M2, M2, M2, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd255, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd50,  MP, MP, MZ, MP, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd100, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_WRITE, 8'd3,   MZ, MZ, MZ, MZ, 9'h101, 9'h0FF));
    send_item(make_item(ACT_READ,  8'd3,   MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_WRITE, 8'd4,   MZ, MZ, MZ, MZ, 9'h0FF, 9'h101));
    send_item(make_item(ACT_READ,  8'd4,   MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_NONE,  8'hFF,  MN, MN, MN, MN, 9'h1FF, 9'h1FF));
    send_item(make_item(ACT_PIVOT, 8'd0,   MN, MZ, MZ, MN, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd255, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd254, MP, MZ, MZ, MN, 9'd0, 9'd0));
    send_item(make_item(ACT_WRITE, 8'd255, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd255, MZ, MZ, MZ, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_PIVOT, 8'd1,   MZ, MN, MN, MZ, 9'd0, 9'd0));
    send_item(make_item(ACT_READ,  8'd128, MZ, MZ, MZ, MZ, 9'd0, 9'd0));

    // random: mostly symmetry pivots, with reads, writes and noise
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 120) hold_off_req = 1'b1;
      if (n == RandomItems - QuietItems) quiet_phase = 1'b1;
      it = make_item(ACT_NONE, 8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     rand_coord(), rand_coord());
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        pick = $urandom_range(0, 7);
        it.action = ACT_PIVOT;
        it.rot_xx = sym[pick][0];
        it.rot_xy = sym[pick][1];
        it.rot_yx = sym[pick][2];
        it.rot_yy = sym[pick][3];
      end else if (sel < 70) begin
        it.action = ACT_PIVOT;
      end else if (sel < 88) begin
        it.action = ACT_READ;
      end else if (sel < 96) begin
        it.action = ACT_WRITE;
      end
      send_item(it);
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d items: %0d pivots applied, %0d rejected, %0d reads, %0d writes",
             tracker.n_applied + tracker.n_rejected + tracker.n_reads + tracker.n_writes,
             tracker.n_applied, tracker.n_rejected, tracker.n_reads, tracker.n_writes);
    $display("random idling on both streams, output hold-off of %0d cycles done=%0b",
             HoldOffCycles, hold_off_done);
    if (tracker.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending.size());
    end
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
